/* hdl/prs_pkg.sv */
// Shared types and codes for the priority reorder stack.
package prs_pkg;

  localparam int unsigned NumW = 32;

  localparam logic [2:0] CMD_PUSH      = 3'd0;
  localparam logic [2:0] CMD_POP       = 3'd1;
  localparam logic [2:0] CMD_PEEK_TOP  = 3'd2;
  localparam logic [2:0] CMD_PEEK_BOT  = 3'd3;
  localparam logic [2:0] CMD_REORG     = 3'd4;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  localparam logic [1:0] PRI_NONE   = 2'd0;
  localparam logic [1:0] PRI_URGENT = 2'd1;
  localparam logic [1:0] PRI_NORMAL = 2'd2;

  // one stored entry; cls set means urgent
  typedef struct packed {
    logic            cls;
    logic [NumW-1:0] num;
  } entry_t;

  // status of the reorganize walker toward the top level
  typedef struct packed {
    logic busy;
    logic wr_en;
    logic done;
  } walk_ctl_t;

endpackage

/* hdl/prs_walk.sv */
// Address sequencer for reorganize: normal entries top-down, then urgent ones bottom-up.
module prs_walk
  import prs_pkg::*;
#(
  parameter int unsigned DEPTH = 64
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic [$clog2(DEPTH+1)-1:0]       count_i,
  input  logic                             rd_class_i,
  output logic [$clog2(DEPTH)-1:0]         rd_addr_o,
  output logic [$clog2(DEPTH)-1:0]         wr_addr_o,
  output walk_ctl_t                        ctl_o
);

  localparam int unsigned AW = $clog2(DEPTH);

  typedef enum logic [3:0] {
    W_IDLE  = 4'b0001,
    W_NORM  = 4'b0010,
    W_URG   = 4'b0100,
    W_DRAIN = 4'b1000
  } walk_state_e;

  walk_state_e st_q, st_d;
  logic [AW-1:0] idx_q, idx_d;
  logic [AW-1:0] last_q, last_d;
  logic [AW-1:0] k_q, k_d;
  logic          rv_q, rv_d;
  logic          rpass_q, rpass_d;
  logic          wr_en;

  // a word read last cycle is kept when its class matches the pass it was read in
  assign wr_en = rv_q && (rd_class_i == rpass_q);

  always_comb begin
    st_d    = st_q;
    idx_d   = idx_q;
    last_d  = last_q;
    k_d     = k_q;
    rv_d    = 1'b0;
    rpass_d = rpass_q;
    if (wr_en) begin
      k_d = k_q + 1'b1;
    end
    case (st_q)
      W_IDLE: begin
        if (start_i) begin
          last_d = AW'(count_i - 1'b1);
          idx_d  = AW'(count_i - 1'b1);
          k_d    = '0;
          st_d   = W_NORM;
        end
      end
      W_NORM: begin
        rv_d    = 1'b1;
        rpass_d = 1'b0;
        if (idx_q == '0) begin
          st_d = W_URG;
        end else begin
          idx_d = idx_q - 1'b1;
        end
      end
      W_URG: begin
        rv_d    = 1'b1;
        rpass_d = 1'b1;
        if (idx_q == last_q) begin
          st_d = W_DRAIN;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      W_DRAIN: begin
        st_d = W_IDLE;
      end
      default: begin
        st_d = W_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= W_IDLE;
      rv_q    <= 1'b0;
      rpass_q <= 1'b0;
      k_q     <= '0;
      idx_q   <= '0;
      last_q  <= '0;
    end else begin
      st_q    <= st_d;
      rv_q    <= rv_d;
      rpass_q <= rpass_d;
      k_q     <= k_d;
      idx_q   <= idx_d;
      last_q  <= last_d;
    end
  end

  assign rd_addr_o   = idx_q;
  assign wr_addr_o   = k_q;
  assign ctl_o.busy  = (st_q != W_IDLE);
  assign ctl_o.wr_en = wr_en;
  assign ctl_o.done  = (st_q == W_DRAIN);

endmodule

/* hdl/priority_reorder_stack.sv */
// Top level of the priority reorder stack: two entry banks, command control and output register.
// Push, pop, unknown commands and commands on an empty stack: result registered in the cycle after accept.
// Peek top/bottom: the bank read is registered first, then the result is loaded into the output register.
// Reorganize: the walker reads one entry per cycle through the
// single bank read port and writes the rebuilt stack into the other bank, which then goes live.
// Input is taken only while no command is in progress; the output register holds one word.
// Reset (rst_ni low, asynchronous) empties the stack; bank contents are not cleared.
module priority_reorder_stack
  import prs_pkg::*;
#(
  parameter int unsigned DEPTH = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,  // entry_num[31:0], entry_priority[33:32], zero pad
  input  logic [2:0]  s_axis_tuser,  // cmd[2:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,  // out_num[31:0], out_priority[33:32], fill_level[40:34]
  output logic [1:0]  m_axis_tuser   // status[1:0]
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_READ  = 3'b010,
    S_REORG = 3'b100
  } state_e;

  state_e          st_q, st_d;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic            bank_q, bank_d;

  entry_t          bank0 [DEPTH];
  entry_t          bank1 [DEPTH];
  entry_t          rd0_q, rd1_q, rd_cur;

  logic            in_acc;
  logic [2:0]      cmd;
  entry_t          push_entry;
  logic            full, empty;
  logic            push_we, walk_start, load;
  logic [AW-1:0]   peek_addr, raddr;
  logic [AW-1:0]   walk_raddr, walk_waddr;
  walk_ctl_t       walk;

  logic            we0, we1;
  logic [AW-1:0]   wa0, wa1;
  entry_t          wd0, wd1;

  logic [1:0]      o_st, o_pri;
  logic [NumW-1:0] o_num;
  logic            ov_q, ov_d;
  logic [1:0]      ost_q, opri_q;
  logic [NumW-1:0] onum_q;
  logic [6:0]      ofill_q;

  assign cmd            = s_axis_tuser;
  assign push_entry.num = s_axis_tdata[NumW-1:0];
  assign push_entry.cls = (s_axis_tdata[33:32] == PRI_URGENT);
  assign full           = (cnt_q == CW'(DEPTH));
  assign empty          = (cnt_q == '0);

  assign s_axis_tready  = (st_q == S_IDLE) && (!ov_q || m_axis_tready);
  assign in_acc         = s_axis_tvalid && s_axis_tready;

  assign peek_addr = (cmd == CMD_PEEK_TOP) ? AW'(cnt_q - 1'b1) : '0;
  assign raddr     = walk.busy ? walk_raddr : peek_addr;
  assign rd_cur    = bank_q ? rd1_q : rd0_q;

  prs_walk #(
    .DEPTH (DEPTH)
  ) u_walk (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (walk_start),
    .count_i    (cnt_q),
    .rd_class_i (rd_cur.cls),
    .rd_addr_o  (walk_raddr),
    .wr_addr_o  (walk_waddr),
    .ctl_o      (walk)
  );

  // push goes to the live bank, the rebuilt stack to the other one
  assign we0 = bank_q ? walk.wr_en : push_we;
  assign we1 = bank_q ? push_we : walk.wr_en;
  assign wa0 = bank_q ? walk_waddr : cnt_q[AW-1:0];
  assign wa1 = bank_q ? cnt_q[AW-1:0] : walk_waddr;
  assign wd0 = bank_q ? rd_cur : push_entry;
  assign wd1 = bank_q ? push_entry : rd_cur;

  always_ff @(posedge clk_i) begin
    if (we0) begin
      bank0[wa0] <= wd0;
    end
    rd0_q <= bank0[raddr];
  end

  always_ff @(posedge clk_i) begin
    if (we1) begin
      bank1[wa1] <= wd1;
    end
    rd1_q <= bank1[raddr];
  end

  always_comb begin
    st_d       = st_q;
    cnt_d      = cnt_q;
    bank_d     = bank_q;
    load       = 1'b0;
    push_we    = 1'b0;
    walk_start = 1'b0;
    o_st       = ST_OK;
    o_num      = '0;
    o_pri      = PRI_NONE;
    case (st_q)
      S_IDLE: begin
        if (in_acc) begin
          case (cmd)
            CMD_PUSH: begin
              load = 1'b1;
              if (full) begin
                o_st = ST_FULL;
              end else begin
                push_we = 1'b1;
                cnt_d   = cnt_q + 1'b1;
              end
            end
            CMD_POP: begin
              load = 1'b1;
              if (empty) begin
                o_st = ST_EMPTY;
              end else begin
                cnt_d = cnt_q - 1'b1;
              end
            end
            CMD_PEEK_TOP, CMD_PEEK_BOT: begin
              if (empty) begin
                load = 1'b1;
                o_st = ST_EMPTY;
              end else begin
                st_d = S_READ;
              end
            end
            CMD_REORG: begin
              if (empty) begin
                load = 1'b1;
              end else begin
                walk_start = 1'b1;
                st_d       = S_REORG;
              end
            end
            default: begin
              load = 1'b1;
            end
          endcase
        end
      end
      S_READ: begin
        load  = 1'b1;
        o_num = rd_cur.num;
        o_pri = rd_cur.cls ? PRI_URGENT : PRI_NORMAL;
        st_d  = S_IDLE;
      end
      S_REORG: begin
        if (walk.done) begin
          bank_d = !bank_q;
          load   = 1'b1;
          st_d   = S_IDLE;
        end
      end
      default: begin
        st_d = S_IDLE;
      end
    endcase
  end

  assign ov_d = load || (ov_q && !m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= S_IDLE;
      cnt_q  <= '0;
      bank_q <= 1'b0;
      ov_q   <= 1'b0;
    end else begin
      st_q   <= st_d;
      cnt_q  <= cnt_d;
      bank_q <= bank_d;
      ov_q   <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      ost_q   <= o_st;
      onum_q  <= o_num;
      opri_q  <= o_pri;
      ofill_q <= 7'(cnt_d);
    end
  end

  assign m_axis_tvalid = ov_q;
  assign m_axis_tuser  = ost_q;
  assign m_axis_tdata  = {7'b0, ofill_q, opri_q, onum_q};

  a_ready_not_walking: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> !walk.busy)
    else $error("input accepted while reorganize in progress");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(DEPTH))
    else $error("entry count above depth");

  a_walk_write_in_reorg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    walk.wr_en |-> (st_q == S_REORG))
    else $error("bank write from walker outside reorganize");

  a_push_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_we |=> (cnt_q == $past(cnt_q) + 1'b1))
    else $error("push did not advance entry count");

  a_reorg_done_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    walk.done |=> (m_axis_tvalid && (st_q == S_IDLE)))
    else $error("reorganize finished without a result word");

endmodule
